### rtl/route_lifo_feasibility_check_assert.svh
// Assertion macros used by the route checker RTL (included by rlfc_route).
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef ROUTE_LIFO_FEASIBILITY_CHECK_ASSERT_SVH
`define ROUTE_LIFO_FEASIBILITY_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RLFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RLFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rlfc_pkg.sv
// Package for the route checker: field widths, failure codes and the
// structs passed between the route logic, the stack cells and the top level.
package rlfc_pkg;

    localparam int STOP_W = 10;
    localparam int TIME_W = 24;
    localparam int DEM_W  = 16;
    localparam int LOAD_W = 18;
    localparam int SUM_W  = 32;
    localparam int CAP_W  = 16;
    localparam int CODE_W = 3;

    typedef enum logic [CODE_W-1:0] {
        FAIL_NONE     = 3'd0,
        FAIL_LATE     = 3'd1,
        FAIL_CAPACITY = 3'd2,
        FAIL_EMPTY    = 3'd3,
        FAIL_MISMATCH = 3'd4,
        FAIL_OPEN     = 3'd5,
        FAIL_OVERFLOW = 3'd6
    } fail_code_t;

    // One stop as it arrives on the input channel.
    typedef struct packed {
        logic [STOP_W-1:0]       partner_pickup_id;
        logic                    last_stop;
        logic                    is_delivery;
        logic                    is_pickup;
        logic signed [DEM_W-1:0] demand;
        logic [TIME_W-1:0]       service_time;
        logic [TIME_W-1:0]       latest_time;
        logic [TIME_W-1:0]       earliest_time;
        logic [TIME_W-1:0]       travel_time;
        logic [STOP_W-1:0]       stop_id;
    } stop_t;

    // Shift command for the stack cells.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    // End-of-route summary, before the cost is summed.
    typedef struct packed {
        logic             valid;
        fail_code_t       code;
        logic [SUM_W-1:0] dist_total;
        logic [SUM_W-1:0] wait_total;
    } route_res_t;

endpackage

### rtl/route_lifo_feasibility_check.sv
// Top level of the route checker: input unpacking, the row of stack cells,
// the route state and a two-register result path. Depends on rlfc_pkg,
// rlfc_cell and rlfc_route.
//
// Usage:
//   s_ channel: one stop per transaction, s_tlast marks the final stop of a
//   route, s_tuser carries the stop kind. A result transaction on the m_
//   channel follows each final stop; other stops produce nothing.
//   cfg_wr_en/cfg_wr_data write vehicle_capacity (reset value 100); write it
//   only while no route is in flight.
// Throughput: one stop per cycle while s_tready is high. The clock, load and
//   sums are updated once per stop, and the stack is a row of cells that all
//   shift together, so the top entry is always in cell 0.
// Result path: the final stop's summary goes into the summary register when
//   it is accepted, then the cost sum goes into the output register.
// Reset: clears the route state, stack count and output valid; capacity
//   returns to 100. Stack cell contents are not reset.
// Stall: while m_tready is low a valid output register holds; one more final
//   stop can be parked in the summary register, after which s_tready drops.
//   Stops that are not final keep flowing as long as s_tready is high.
module route_lifo_feasibility_check #(
    parameter int STACK_DEPTH = 64,
    parameter int ID_BITS     = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: vehicle_capacity
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    // Stops
    input  logic         s_tvalid,
    output logic         s_tready,
    // [9:0] stop_id, [33:10] travel_time, [57:34] earliest_time,
    // [81:58] latest_time, [105:82] service_time, [121:106] demand,
    // [131:122] partner_pickup_id, [135:132] zero
    input  logic [135:0] s_tdata,
    // [0] is_pickup, [1] is_delivery
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    // Results
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] feasible, [32:1] total cost, [35:33] fail_reason, [39:36] zero
    output logic [39:0]  m_tdata
);
    import rlfc_pkg::*;

    logic [CAP_W-1:0] capacity_reg;

    // Hold capacity until the next write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(100);
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    stop_t stop;
    logic  accept;
    logic  p_move;

    // Unpack the stop transaction.
    always_comb begin
        stop.stop_id           = s_tdata[9:0];
        stop.travel_time       = s_tdata[33:10];
        stop.earliest_time     = s_tdata[57:34];
        stop.latest_time       = s_tdata[81:58];
        stop.service_time      = s_tdata[105:82];
        stop.demand            = s_tdata[121:106];
        stop.partner_pickup_id = s_tdata[131:122];
        stop.is_pickup         = s_tuser[0];
        stop.is_delivery       = s_tuser[1];
        stop.last_stop         = s_tlast;
    end

    logic [ID_BITS-1:0] push_id;
    stack_op_t          stack_op;
    route_res_t         res;
    logic [ID_BITS-1:0] cell_q [STACK_DEPTH];

    rlfc_route #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_route (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .capacity   (capacity_reg),
        .stop_valid (accept),
        .stop       (stop),
        .stack_top  (cell_q[0]),
        .push_id    (push_id),
        .stack_op   (stack_op),
        .res        (res)
    );

    // Stack row: cell 0 is the top, pushes feed it from the stop id.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [ID_BITS-1:0] above, below;
        if (i == 0) begin : g_top
            assign above = push_id;
        end else begin : g_mid
            assign above = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_bottom
            assign below = '0;
        end else begin : g_inner
            assign below = cell_q[i+1];
        end
        rlfc_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .aclk       (aclk),
            .op         (stack_op),
            .from_above (above),
            .from_below (below),
            .q          (cell_q[i])
        );
    end

    // Result path: summary register, then output register.
    logic             p_valid_reg;
    fail_code_t       p_code_reg;
    logic [SUM_W-1:0] p_dist_reg, p_wait_reg;
    logic             o_valid_reg;
    logic [39:0]      o_data_reg, o_data_next;
    logic [SUM_W:0]   cost_sum;
    logic [SUM_W-1:0] cost_sat;

    assign p_move   = !o_valid_reg || m_tready;
    assign s_tready = !p_valid_reg || p_move;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (accept && res.valid) begin
            p_valid_reg <= 1'b1;
        end else if (p_move) begin
            p_valid_reg <= 1'b0;
        end
    end

    // Park the route summary; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            p_code_reg <= res.code;
            p_dist_reg <= res.dist_total;
            p_wait_reg <= res.wait_total;
        end
    end

    // Cost is distance plus wait, saturating; zero for a failed route.
    always_comb begin
        cost_sum    = {1'b0, p_dist_reg} + {1'b0, p_wait_reg};
        cost_sat    = cost_sum[SUM_W] ? {SUM_W{1'b1}} : cost_sum[SUM_W-1:0];
        o_data_next = '0;
        if (p_code_reg == FAIL_NONE) begin
            o_data_next[0]    = 1'b1;
            o_data_next[32:1] = cost_sat;
        end
        o_data_next[35:33] = p_code_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (p_move) begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_move && p_valid_reg) begin
            o_data_reg <= o_data_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

endmodule

### rtl/rlfc_cell.sv
// One entry of the shifting pickup stack.
// Depends on rlfc_pkg for the shift command struct.
module rlfc_cell #(
    parameter int ID_BITS = 10
) (
    input  logic                aclk,
    input  rlfc_pkg::stack_op_t op,
    input  logic [ID_BITS-1:0]  from_above,
    input  logic [ID_BITS-1:0]  from_below,
    output logic [ID_BITS-1:0]  q
);
    import rlfc_pkg::*;

    logic [ID_BITS-1:0] data_reg;

    // Push moves entries away from the top, pop moves them toward it.
    always_ff @(posedge aclk) begin
        if (op.push) begin
            data_reg <= from_above;
        end else if (op.pop) begin
            data_reg <= from_below;
        end
    end

    assign q = data_reg;

endmodule

### rtl/rlfc_route.sv
// Per-stop route state: clock, load, sums, failure code and stack count.
// Depends on rlfc_pkg and the assertion macro header.
module rlfc_route #(
    parameter int STACK_DEPTH = 64,
    parameter int ID_BITS     = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rlfc_pkg::CAP_W-1:0]    capacity,
    input  logic                          stop_valid,
    input  rlfc_pkg::stop_t               stop,
    input  logic [ID_BITS-1:0]            stack_top,
    output logic [ID_BITS-1:0]            push_id,
    output rlfc_pkg::stack_op_t           stack_op,
    output rlfc_pkg::route_res_t          res
);
    import rlfc_pkg::*;
    `include "route_lifo_feasibility_check_assert.svh"

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int PAD_W = (ID_BITS > STOP_W) ? ID_BITS : STOP_W;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {1'b0, {(LOAD_W-1){1'b1}}};
    localparam logic [LOAD_W-1:0] LOAD_MIN = {1'b1, {(LOAD_W-1){1'b0}}};

    logic [SUM_W-1:0]  clock_reg, clock_next;
    logic [LOAD_W-1:0] load_reg, load_next;
    logic [SUM_W-1:0]  wait_reg, wait_next;
    logic [SUM_W-1:0]  dist_reg, dist_next;
    logic              start_reg, start_next;
    fail_code_t        fail_reg, fail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [PAD_W-1:0]   stop_pad, partner_pad;
    logic [ID_BITS-1:0] stop_k, partner_k;

    // Compare ids on their low ID_BITS bits.
    assign stop_pad    = PAD_W'(stop.stop_id);
    assign partner_pad = PAD_W'(stop.partner_pickup_id);
    assign stop_k      = stop_pad[ID_BITS-1:0];
    assign partner_k   = partner_pad[ID_BITS-1:0];
    assign push_id     = stop_k;

    logic [SUM_W:0]    arr_sum, dist_sum, wait_sum, serve_sum;
    logic [SUM_W-1:0]  arrive, early_w, late_w, ready_t;
    logic [SUM_W-1:0]  dist_sat, wait_sat, depart;
    logic              is_early, late_hit;
    logic [LOAD_W:0]   load_sum;
    logic [LOAD_W-1:0] load_sat;
    logic              over_cap, pick_ok, drop_ok, stack_full;
    logic [ID_BITS-1:0] match_id;

    // Time and load arithmetic for the current stop.
    always_comb begin
        early_w   = SUM_W'(stop.earliest_time);
        late_w    = SUM_W'(stop.latest_time);
        arr_sum   = {1'b0, clock_reg} + (SUM_W+1)'(stop.travel_time);
        arrive    = arr_sum[SUM_W] ? {SUM_W{1'b1}} : arr_sum[SUM_W-1:0];
        dist_sum  = {1'b0, dist_reg} + (SUM_W+1)'(stop.travel_time);
        dist_sat  = dist_sum[SUM_W] ? {SUM_W{1'b1}} : dist_sum[SUM_W-1:0];
        is_early  = (arrive <= early_w);
        wait_sum  = {1'b0, wait_reg} + {1'b0, early_w - arrive};
        wait_sat  = is_early ? (wait_sum[SUM_W] ? {SUM_W{1'b1}} : wait_sum[SUM_W-1:0])
                             : wait_reg;
        ready_t   = is_early ? early_w : arrive;
        late_hit  = !is_early && !start_reg && (arrive > late_w);
        serve_sum = {1'b0, ready_t} + (SUM_W+1)'(stop.service_time);
        depart    = serve_sum[SUM_W] ? {SUM_W{1'b1}} : serve_sum[SUM_W-1:0];

        load_sum = {load_reg[LOAD_W-1], load_reg}
                 + {{(LOAD_W+1-DEM_W){stop.demand[DEM_W-1]}}, stop.demand};
        if (load_sum[LOAD_W] != load_sum[LOAD_W-1]) begin
            load_sat = load_sum[LOAD_W] ? LOAD_MIN : LOAD_MAX;
        end else begin
            load_sat = load_sum[LOAD_W-1:0];
        end
        over_cap = $signed(load_sat) > $signed({{(LOAD_W-CAP_W){1'b0}}, capacity});

        pick_ok    = stop.is_pickup && (stop_k != '0);
        drop_ok    = stop.is_delivery && (stop_k != '0);
        stack_full = (cnt_reg == CNT_W'(STACK_DEPTH));
        // A stop that picks up and delivers checks against its own push.
        match_id   = pick_ok ? stop_k : stack_top;
    end

    // Next state, stack command and end-of-route summary.
    always_comb begin
        clock_next = clock_reg;
        load_next  = load_reg;
        wait_next  = wait_reg;
        dist_next  = dist_reg;
        start_next = start_reg;
        fail_next  = fail_reg;
        cnt_next   = cnt_reg;
        stack_op   = '0;
        res        = '0;

        if (stop_valid) begin
            if (fail_reg != FAIL_NONE) begin
                start_next = 1'b0;
            end else begin
                dist_next  = dist_sat;
                wait_next  = wait_sat;
                clock_next = arrive;
                if (late_hit) begin
                    fail_next = FAIL_LATE;
                end else begin
                    clock_next = depart;
                    load_next  = load_sat;
                    priority if (start_reg) begin
                        start_next = 1'b0;
                    end else if (over_cap) begin
                        fail_next = FAIL_CAPACITY;
                    end else if (pick_ok && stack_full) begin
                        fail_next = FAIL_OVERFLOW;
                    end else if (drop_ok && !pick_ok && (cnt_reg == '0)) begin
                        fail_next = FAIL_EMPTY;
                    end else if (drop_ok && (match_id != partner_k)) begin
                        fail_next = FAIL_MISMATCH;
                    end else if (drop_ok && !pick_ok) begin
                        stack_op.pop = 1'b1;
                        cnt_next     = cnt_reg - CNT_W'(1);
                    end else if (pick_ok && !drop_ok) begin
                        stack_op.push = 1'b1;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end else begin
                        // Push and matching pop cancel out.
                        stack_op = '0;
                    end
                end
            end

            if (stop.last_stop) begin
                res.valid      = 1'b1;
                res.code       = ((fail_next == FAIL_NONE) && (cnt_next != '0)) ?
                                 FAIL_OPEN : fail_next;
                res.dist_total = dist_next;
                res.wait_total = wait_next;
                clock_next     = '0;
                load_next      = '0;
                wait_next      = '0;
                dist_next      = '0;
                start_next     = 1'b1;
                fail_next      = FAIL_NONE;
                cnt_next       = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= '0;
            load_reg  <= '0;
            wait_reg  <= '0;
            dist_reg  <= '0;
            start_reg <= 1'b1;
            fail_reg  <= FAIL_NONE;
            cnt_reg   <= '0;
        end else begin
            clock_reg <= clock_next;
            load_reg  <= load_next;
            wait_reg  <= wait_next;
            dist_reg  <= dist_next;
            start_reg <= start_next;
            fail_reg  <= fail_next;
            cnt_reg   <= cnt_next;
        end
    end

    `RLFC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH), "stack count over depth")
    `RLFC_ASSERT_IMP(a_op_excl, 1'b1, !(stack_op.push && stack_op.pop), "push and pop together")
    `RLFC_ASSERT_IMP(a_no_op_failed, fail_reg != FAIL_NONE, stack_op == '0, "stack moved after failure")
    `RLFC_ASSERT_NXT(a_route_clear, stop_valid && stop.last_stop, (cnt_reg == '0) && start_reg && (fail_reg == FAIL_NONE), "route state not cleared")

endmodule

### tb/sv/route_lifo_feasibility_check_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for route_lifo_feasibility_check: directed and random routes,
// a built-in route predictor and a scoreboard on the result stream.
// Depends on rlfc_pkg and the route_lifo_feasibility_check RTL.
module route_lifo_feasibility_check_tb;

    import rlfc_pkg::*;

    localparam int          MAX_DEPTH = 64;
    localparam int          ID_W      = 10;
    localparam logic [23:0] T_MAX     = 24'hFFFFFF;
    localparam int          LOAD_HI   = 131071;
    localparam int          LOAD_LO   = -131072;

    // One route verdict as the block reports it.
    typedef struct {
        logic             feasible;
        logic [SUM_W-1:0] cost;
        fail_code_t       reason;
    } route_verdict_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    // Route state of the predictor.
    logic [15:0]      cap_limit;
    logic [SUM_W-1:0] trip_clock;
    logic [SUM_W-1:0] trip_wait;
    logic [SUM_W-1:0] trip_dist;
    int               trip_load;
    bit               trip_first;
    fail_code_t       trip_fail;
    logic [ID_W-1:0]  open_stack [MAX_DEPTH];
    int               open_depth;

    // Verdicts owed by the block, oldest first.
    route_verdict_t verdicts_due[$];

    bit idle_on = 1'b1;
    int fault_count = 0;
    int stops_sent = 0;
    int routes_seen = 0;
    int cap_writes = 0;
    int outcome_hits[8];

    route_lifo_feasibility_check #(
        .STACK_DEPTH (MAX_DEPTH),
        .ID_BITS     (ID_W)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic void clear_route();
        trip_clock = '0;
        trip_wait  = '0;
        trip_dist  = '0;
        trip_load  = 0;
        trip_first = 1'b1;
        trip_fail  = FAIL_NONE;
        open_depth = 0;
    endfunction

    // Apply one stop to a route that has not failed yet.
    function automatic void walk_stop(stop_t st);
        int load_next;
        trip_clock = sum_sat(trip_clock, 32'(st.travel_time));
        trip_dist  = sum_sat(trip_dist, 32'(st.travel_time));
        // Early arrival waits for the window; a late one fails except on the first stop.
        if (trip_clock <= 32'(st.earliest_time)) begin
            trip_wait  = sum_sat(trip_wait, 32'(st.earliest_time) - trip_clock);
            trip_clock = 32'(st.earliest_time);
        end else if (!trip_first && trip_clock > 32'(st.latest_time)) begin
            trip_fail = FAIL_LATE;
            return;
        end
        trip_clock = sum_sat(trip_clock, 32'(st.service_time));
        // Clamp the load into its 18-bit signed range.
        load_next = trip_load + int'($signed(st.demand));
        if (load_next > LOAD_HI) load_next = LOAD_HI;
        if (load_next < LOAD_LO) load_next = LOAD_LO;
        trip_load = load_next;
        if (trip_first) begin
            trip_first = 1'b0;
            return;
        end
        if (trip_load > int'(cap_limit)) begin
            trip_fail = FAIL_CAPACITY;
            return;
        end
        // Push before pop, so a stop that is both can serve itself.
        if (st.is_pickup && st.stop_id != '0) begin
            if (open_depth >= MAX_DEPTH) begin
                trip_fail = FAIL_OVERFLOW;
                return;
            end
            open_stack[open_depth] = st.stop_id;
            open_depth++;
        end
        if (st.is_delivery && st.stop_id != '0) begin
            if (open_depth == 0) begin
                trip_fail = FAIL_EMPTY;
                return;
            end
            if (open_stack[open_depth-1] != st.partner_pickup_id) begin
                trip_fail = FAIL_MISMATCH;
                return;
            end
            open_depth--;
        end
    endfunction

    // Advance the predictor by one accepted stop; queue a verdict on the final stop.
    function automatic void predict_stop(stop_t st);
        route_verdict_t v;
        if (trip_fail == FAIL_NONE) walk_stop(st);
        else trip_first = 1'b0;
        if (!st.last_stop) return;
        if (trip_fail == FAIL_NONE && open_depth != 0) trip_fail = FAIL_OPEN;
        v.feasible = (trip_fail == FAIL_NONE);
        v.cost     = v.feasible ? sum_sat(trip_dist, trip_wait) : '0;
        v.reason   = trip_fail;
        verdicts_due.insert(verdicts_due.size(), v);
        clear_route();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stop_t mk_stop(logic [ID_W-1:0] id, logic [23:0] travel,
                                      logic [23:0] early, logic [23:0] late,
                                      logic [23:0] serve, logic signed [15:0] demand,
                                      int pick, int drop, logic [ID_W-1:0] partner, int last);
        stop_t st;
        st.stop_id           = id;
        st.travel_time       = travel;
        st.earliest_time     = early;
        st.latest_time       = late;
        st.service_time      = serve;
        st.demand            = demand;
        st.is_pickup         = 1'(pick);
        st.is_delivery       = 1'(drop);
        st.partner_pickup_id = partner;
        st.last_stop         = 1'(last);
        return st;
    endfunction

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Drive one stop after a random gap and hold it until the transaction completes.
    task automatic send_stop(stop_t st);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {4'b0, st.partner_pickup_id, st.demand, st.service_time,
                    st.latest_time, st.earliest_time, st.travel_time, st.stop_id};
        s_tuser  = {st.is_delivery, st.is_pickup};
        s_tlast  = st.last_stop;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_stop(st);
        stops_sent++;
    endtask

    // Drop valid and hold off until every owed verdict is back or the limit runs
    // out, then let the pipeline settle.
    task automatic drain_results(int limit_cycles);
        int n = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (verdicts_due.size() != 0 && n < limit_cycles) begin
            @(posedge aclk);
            n++;
        end
        repeat (4) @(negedge aclk);
    endtask

    // Write vehicle_capacity while the block is idle.
    task automatic set_capacity(logic [15:0] value);
        drain_results(5000);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        cap_limit   = value;
        cap_writes++;
    endtask

    // Build a mostly well-formed route: deliveries follow open pickups in LIFO
    // order, windows mostly fit, with occasional late windows, bad partners,
    // depot stops and full-range demand thrown in.
    task automatic run_random_route(int n_stops);
        logic [ID_W-1:0] open_ids[$];
        logic [31:0]     t_now = 0;
        logic [31:0]     arrive;
        stop_t           st;
        int              left;
        bit              leave_open;
        leave_open = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n_stops; k++) begin
            left = n_stops - 1 - k;
            st = '0;
            st.travel_time = ($urandom_range(0, 19) == 0) ? 24'($urandom)
                                                           : 24'($urandom_range(0, 255));
            arrive = t_now + 32'(st.travel_time);
            st.earliest_time = $urandom_range(0, 1) ? 24'(arrive + $urandom_range(0, 300))
                                                    : 24'($urandom_range(0, arrive));
            st.latest_time = ($urandom_range(0, 11) == 0) ? 24'($urandom_range(0, arrive))
                           : 24'(arrive + 300 + $urandom_range(0, 4095));
            st.service_time = 24'($urandom_range(0, 255));
            st.partner_pickup_id = ID_W'($urandom);
            t_now = ((arrive > 32'(st.earliest_time)) ? arrive : 32'(st.earliest_time))
                    + 32'(st.service_time);
            if (k == 0) begin
                // The first stop is never checked; any kind goes.
                st.stop_id     = ID_W'($urandom);
                st.is_pickup   = 1'($urandom_range(0, 1));
                st.is_delivery = 1'($urandom_range(0, 1));
                st.demand      = 16'($urandom_range(0, 60) - 30);
            end else if (open_ids.size() != 0 &&
                         ((open_ids.size() >= left && !leave_open) || $urandom_range(0, 1))) begin
                st.stop_id     = ID_W'($urandom_range(1, 1023));
                st.is_delivery = 1'b1;
                st.partner_pickup_id = ($urandom_range(0, 19) == 0) ? ID_W'($urandom)
                                                                    : open_ids[$];
                void'(open_ids.pop_back());
                st.demand = 16'(-int'($urandom_range(0, 30)));
            end else begin
                st.stop_id   = ($urandom_range(0, 19) == 0) ? '0 : ID_W'($urandom_range(1, 1023));
                st.is_pickup = 1'b1;
                st.demand    = 16'($urandom_range(0, 30));
                if ($urandom_range(0, 9) == 0) begin
                    // Pickup and delivery at one stop: it serves itself.
                    st.is_delivery       = 1'b1;
                    st.partner_pickup_id = st.stop_id;
                end else if (st.stop_id != '0) begin
                    open_ids.insert(open_ids.size(), st.stop_id);
                end
            end
            if ($urandom_range(0, 24) == 0) st.demand = 16'($urandom);
            st.last_stop = (left == 0);
            send_stop(st);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short routes that each hit one outcome at the field extremes.
    task automatic test_basic_routes();
        // Single-stop route: the first stop carries maxima in every field but latest_time and is not checked.
        send_stop(mk_stop(10'd1023, T_MAX, T_MAX, 24'd0, T_MAX, 16'sd32767, 1, 1, 10'd1023, 1));
        // Feasible pickup/delivery pair with a wait at the depot.
        send_stop(mk_stop(10'd0, 24'h100, 24'h200, T_MAX, 24'h10, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd7, 24'h80, 24'd0, T_MAX, 24'd0, 16'sd40, 1, 0, 10'd0, 0));
        send_stop(mk_stop(10'd9, 24'h20, 24'd0, T_MAX, 24'd0, -16'sd40, 0, 1, 10'd7, 1));
        // Late on the first stop is ignored, late on the second fails; the rest is ignored.
        send_stop(mk_stop(10'd0, T_MAX, 24'd0, 24'd0, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd3, 24'd0, 24'd0, 24'd0, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd5, 24'd0, 24'd0, T_MAX, 24'd0, -16'sd32768, 1, 1, 10'd5, 1));
        // Load one over capacity.
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd100, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd3, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd1, 1, 0, 10'd0, 1));
        // Delivery with nothing open.
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd4, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 1, 10'd2, 1));
        // Delivery whose partner is not on top.
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd1023, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd5, 1, 0, 10'd0, 0));
        send_stop(mk_stop(10'd600, 24'd1, 24'd0, T_MAX, 24'd0, -16'sd5, 0, 1, 10'd1022, 1));
        // Route ends with a pickup still open.
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd5, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd5, 1, 0, 10'd0, 1));
        // Stop that is both kinds serves itself; a depot stop leaves the stack alone.
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd12, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 1, 1, 10'd12, 0));
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 1, 1, 10'd99, 1));
        // Stop that is both kinds with a foreign partner fails the match.
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd12, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd0, 1, 1, 10'd11, 1));
    endtask

    // Capacity extremes: clamp the load at its floor with capacity 0, then fill
    // exactly to 65535 and one past it.
    task automatic test_load_limits();
        set_capacity(16'd0);
        for (int i = 0; i < 5; i++)
            send_stop(mk_stop(ID_W'($urandom), 24'd1, 24'd0, T_MAX, 24'd0, -16'sd32768,
                              0, 0, 10'd0, 0));
        for (int i = 0; i < 4; i++)
            send_stop(mk_stop(ID_W'($urandom), 24'd1, 24'd0, T_MAX, 24'd0, 16'sd32767,
                              0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd8, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd10, 0, 0, 10'd0, 1));
        set_capacity(16'hFFFF);
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd32767, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd8, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd32767, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd9, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd1, 0, 0, 10'd0, 1));
        send_stop(mk_stop(10'd0, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd32767, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd8, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd32767, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd9, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd1, 0, 0, 10'd0, 0));
        send_stop(mk_stop(10'd10, 24'd1, 24'd0, T_MAX, 24'd0, 16'sd1, 0, 0, 10'd0, 1));
        set_capacity(16'($urandom));
        for (int r = 0; r < 4; r++) run_random_route($urandom_range(2, 8));
    endtask

    // Fill the stack to the brim: one push too many overflows, while a full
    // stack unwound in LIFO order closes cleanly.
    task automatic test_stack_full();
        set_capacity(16'd100);
        send_stop(mk_stop(10'd0, 24'd4, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        for (int i = 1; i <= MAX_DEPTH; i++)
            send_stop(mk_stop(ID_W'(i), 24'd4, 24'd0, T_MAX, 24'd1, 16'sd0, 1, 0, 10'd0, 0));
        send_stop(mk_stop(10'd100, 24'd4, 24'd0, T_MAX, 24'd0, 16'sd0, 1, 0, 10'd0, 1));

        send_stop(mk_stop(10'd0, 24'd4, 24'd0, T_MAX, 24'd0, 16'sd0, 0, 0, 10'd0, 0));
        for (int i = 1; i <= MAX_DEPTH; i++)
            send_stop(mk_stop(ID_W'(i * 13 + 2), 24'd4, 24'd0, T_MAX, 24'd1, 16'sd1,
                              1, 0, 10'd0, 0));
        for (int i = MAX_DEPTH; i >= 1; i--)
            send_stop(mk_stop(ID_W'(i + 700), 24'd4, 24'd0, T_MAX, 24'd1, -16'sd1,
                              0, 1, ID_W'(i * 13 + 2), int'(i == 1)));
    endtask

    // Raw stops with every field random, so every stop field bit toggles.
    task automatic test_noise();
        stop_t st;
        for (int i = 0; i < 150; i++) begin
            st = mk_stop(ID_W'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom), 16'($urandom), $urandom_range(0, 1),
                         $urandom_range(0, 1), ID_W'($urandom),
                         int'((i == 149) || ($urandom_range(0, 3) == 0)));
            send_stop(st);
        end
    endtask

    // Bulk of the run: well-formed routes of mostly short length, new capacity
    // every few dozen routes, and stretches with idling switched off.
    task automatic test_random_routes();
        int start = stops_sent;
        int route_no = 0;
        while (stops_sent - start < 750) begin
            if (route_no % 40 == 39) set_capacity(16'($urandom_range(20, 400)));
            if (route_no % 15 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (route_no == 60) drain_results(5000);
            run_random_route(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                         : $urandom_range(1, 12));
            route_no++;
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Draw a stall per result; half the time hold ready low until a result waits.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 11) : 0;
            @(negedge aclk);
            if (stall != 0) begin
                m_tready = 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    while (!m_tvalid) @(posedge aclk);
                    @(negedge aclk);
                end
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each result transaction with the oldest owed verdict.
    always @(posedge aclk) begin : check_results
        route_verdict_t   want;
        logic             got_ok;
        logic [SUM_W-1:0] got_cost;
        logic [2:0]       got_why;
        if (aresetn && m_tvalid && m_tready) begin
            got_ok   = m_tdata[0];
            got_cost = m_tdata[32:1];
            got_why  = m_tdata[35:33];
            routes_seen++;
            outcome_hits[got_why]++;
            if (verdicts_due.size() == 0) begin
                note_fault($sformatf("result with nothing owed: feasible=%0b cost=%h reason=%0d",
                                     got_ok, got_cost, got_why));
            end else begin
                want = verdicts_due.pop_front();
                if (got_ok !== want.feasible || got_cost !== want.cost ||
                    got_why !== want.reason)
                    note_fault($sformatf({"route %0d: expected feasible=%0b cost=%h reason=%0d,",
                                          " got feasible=%0b cost=%h reason=%0d"},
                                         routes_seen, want.feasible, want.cost, want.reason,
                                         got_ok, got_cost, got_why));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        cap_limit   = 16'd100;
        clear_route();
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        test_basic_routes();
        test_load_limits();
        test_stack_full();
        test_noise();
        test_random_routes();

        // Wait out the last verdicts plus the two-register output path.
        drain_results(20000);
        repeat (8) @(posedge aclk);
        if (verdicts_due.size() != 0)
            note_fault($sformatf("%0d verdicts never arrived", verdicts_due.size()));

        $display("Covered %0d stops in %0d routes under %0d capacity writes.",
                 stops_sent, routes_seen, cap_writes);
        $display("Outcomes: ok %0d late %0d cap %0d empty %0d mismatch %0d open %0d ovf %0d",
                 outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
                 outcome_hits[4], outcome_hits[5], outcome_hits[6]);
        if (fault_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d faults in total", fault_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("Timeout with %0d verdicts owed", verdicts_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
